>>> sv/rla_pkg.sv
`timescale 1ns / 1ps
// rla_pkg: shared constants, register indexes and the CORDIC arctangent table
// for the attitude/speed step core. No dependencies.
package rla_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // CORDIC datapath: speed in Q14, gain growth and sign need 34 bits
   localparam int CORDIC_W  = 34;
   localparam int ZW        = 34;
   localparam int FRAC_BITS = 14;

   // 16*g/(2*pi) in Q16
   localparam logic [20:0] TURN_Q16 = 21'd1636593;
   // inverse CORDIC gain in Q30
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

   localparam logic signed [17:0] VEL_MAX = 18'sh1FFFF;
   localparam logic signed [17:0] VEL_MIN = 18'sh20000;

   localparam logic [9:0]  MAX_G_RST     = 10'd240;
   localparam logic [11:0] MAX_ACCEL_RST = 12'd1280;

   localparam logic [0:0] REG_MAX_G     = 1'd0;
   localparam logic [0:0] REG_MAX_ACCEL = 1'd1;

   // atan(2^-i) in 2^32-per-circle units
   function automatic logic [31:0] atan_of(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> sv/rla_div_cell.sv
`timescale 1ns / 1ps
// rla_div_cell: one restoring-division cell, produces one quotient bit.
// Standalone, no package use.
module rla_div_cell #(
   parameter int W  = 64,
   parameter int QW = 17,
   parameter int K  = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  rem_up,
   input  logic [W-1:0]  den_up,
   input  logic [QW-1:0] quo_up,
   output logic [W-1:0]  rem_dn,
   output logic [W-1:0]  den_dn,
   output logic [QW-1:0] quo_dn
);

   logic [W-1:0]  shd;
   logic          ge;
   logic [W-1:0]  rem_ff, rem_in, den_ff;
   logic [QW-1:0] quo_ff, quo_in;

   assign shd    = den_up << K;
   assign ge     = rem_up >= shd;
   assign rem_in = ge ? rem_up - shd : rem_up;
   assign quo_in = {quo_up[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_up;
         quo_ff <= quo_in;
      end
   end

   assign rem_dn = rem_ff;
   assign den_dn = den_ff;
   assign quo_dn = quo_ff;

endmodule

>>> sv/rla_divider.sv
`timescale 1ns / 1ps
// rla_divider: chain of QW division cells, MSB of the quotient first.
// Uses rla_div_cell.
module rla_divider #(
   parameter int W  = 64,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  rem_up,
   input  logic [W-1:0]  den_up,
   output logic [QW-1:0] quo_dn
);

   logic [W-1:0]  rem_w [0:QW];
   logic [W-1:0]  den_w [0:QW];
   logic [QW-1:0] quo_w [0:QW];

   assign rem_w[0] = rem_up;
   assign den_w[0] = den_up;
   assign quo_w[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      rla_div_cell #(.W(W), .QW(QW), .K(QW-1-i)) u_cell (
         .clock  (clock),
         .en     (en),
         .rem_up (rem_w[i]),
         .den_up (den_w[i]),
         .quo_up (quo_w[i]),
         .rem_dn (rem_w[i+1]),
         .den_dn (den_w[i+1]),
         .quo_dn (quo_w[i+1])
      );
   end

   assign quo_dn = quo_w[QW];

endmodule

>>> sv/rla_cordic_cell.sv
`timescale 1ns / 1ps
// rla_cordic_cell: one CORDIC rotation micro-step, registered.
// Uses rla_pkg (arctangent table, widths).
module rla_cordic_cell import rla_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [CORDIC_W-1:0] x_up,
   input  logic signed [CORDIC_W-1:0] y_up,
   input  logic signed [ZW-1:0]       z_up,
   output logic signed [CORDIC_W-1:0] x_dn,
   output logic signed [CORDIC_W-1:0] y_dn,
   output logic signed [ZW-1:0]       z_dn
);

   logic signed [ZW-1:0]       ang;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]       z_ff, z_in;

   assign ang = $signed(ZW'(atan_of(5'(IDX))));
   assign xs  = x_up >>> IDX;
   assign ys  = y_up >>> IDX;

   always_comb begin
      if (z_up >= 0) begin
         x_in = x_up - ys;
         y_in = y_up + xs;
         z_in = z_up - ang;
      end else begin
         x_in = x_up + ys;
         y_in = y_up - xs;
         z_in = z_up + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_dn = x_ff;
   assign y_dn = y_ff;
   assign z_dn = z_ff;

endmodule

>>> sv/rla_rotator.sv
`timescale 1ns / 1ps
// rla_rotator: rotates (x,0) by a binary angle: quadrant fold, a row of
// CORDIC cells, gain multiply and rounding. Uses rla_pkg, rla_cordic_cell.
module rla_rotator import rla_pkg::*; #(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [CORDIC_W-1:0] x_up,
   input  logic [ANGLE_BITS-1:0]      ang_up,
   output logic signed [CORDIC_W-1:0] x_dn,
   output logic signed [CORDIC_W-1:0] y_dn
);

   localparam int PW = CORDIC_W + 32;
   localparam logic signed [PW-1:0] HALF30 = PW'(64'sd1 <<< 29);

   logic [31:0] z32, zsum, zfold;
   logic        flip;

   logic signed [CORDIC_W-1:0] x0_ff, x0_in;
   logic signed [ZW-1:0]       z0_ff, z0_in;

   logic signed [CORDIC_W-1:0] x_w [0:CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] y_w [0:CORDIC_STAGES];
   logic signed [ZW-1:0]       z_w [0:CORDIC_STAGES];

   logic signed [PW-1:0]       px_ff, px_in, py_ff, py_in;
   logic signed [CORDIC_W-1:0] rx_ff, rx_in, ry_ff, ry_in;

   // fold the left half plane onto the right one
   assign z32   = 32'(ang_up) << (32 - ANGLE_BITS);
   assign zsum  = z32 + 32'h4000_0000;
   assign flip  = zsum[31];
   assign zfold = flip ? z32 - 32'h8000_0000 : z32;
   assign x0_in = flip ? -x_up : x_up;
   assign z0_in = ZW'($signed(zfold));

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         z0_ff <= z0_in;
      end
   end

   assign x_w[0] = x0_ff;
   assign y_w[0] = '0;
   assign z_w[0] = z0_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      rla_cordic_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .en    (en),
         .x_up  (x_w[i]),
         .y_up  (y_w[i]),
         .z_up  (z_w[i]),
         .x_dn  (x_w[i+1]),
         .y_dn  (y_w[i+1]),
         .z_dn  (z_w[i+1])
      );
   end

   assign px_in = x_w[CORDIC_STAGES] * GAIN_Q30;
   assign py_in = y_w[CORDIC_STAGES] * GAIN_Q30;
   assign rx_in = CORDIC_W'((px_ff + HALF30) >>> 30);
   assign ry_in = CORDIC_W'((py_ff + HALF30) >>> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign x_dn = rx_ff;
   assign y_dn = ry_ff;

endmodule

>>> sv/rate_limited_attitude_speed_step_core.sv
`timescale 1ns / 1ps
// rate_limited_attitude_speed_step_core: top level of the frame step core.
// Uses rla_pkg, rla_divider, rla_rotator.
//
// One frame step per word: heading and pitch move toward their commands by
// at most the turn step max_g*g*dt/speed (speed floored at 1 m/s), speed
// moves by at most max_accel*dt, and the word out also carries a cosmetic
// bank angle and NED velocity from two chained CORDIC rotations. The core
// is fully pipelined and takes one word every cycle unless the response
// stalls; a stalled output register freezes the whole pipe. The path runs
// through stages 0 and 1, the turn-step divider (ANGLE_BITS+1 cells), stage
// 2 and the two rotators, the bank divider running beside the first one,
// then the response register. The user writes registers through
// csr_we/csr_index/csr_wdata only while idle; the core does not enforce it.
module rate_limited_attitude_speed_step_core import rla_pkg::*; #(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [11:0]        csr_wdata,
   // request word
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_cmd_heading,
   input  logic signed [15:0] req_cmd_pitch,
   input  logic [16:0]        req_cmd_speed,
   input  logic [15:0]        req_cur_heading,
   input  logic signed [15:0] req_cur_pitch,
   input  logic [16:0]        req_cur_speed,
   input  logic [15:0]        req_frame_time,
   // response word
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_new_heading,
   output logic signed [15:0] rsp_new_pitch,
   output logic signed [14:0] rsp_bank_angle,
   output logic [16:0]        rsp_new_speed,
   output logic signed [17:0] rsp_vel_north,
   output logic signed [17:0] rsp_vel_east,
   output logic signed [17:0] rsp_vel_down
);

   // pipeline geometry
   localparam int W1      = 48 + ANGLE_BITS;        // turn-step dividend
   localparam int Q1      = ANGLE_BITS + 1;         // turn-step quotient bits
   localparam int W2      = 2 * ANGLE_BITS + 1;     // bank dividend
   localparam int Q2      = ANGLE_BITS - 2;         // bank quotient bits
   localparam int DW6     = ANGLE_BITS + 2;         // 6*step
   localparam int ROT_LAT = CORDIC_STAGES + 3;
   localparam int PL      = 2 * ROT_LAT;            // stages after the step stage
   localparam int BL      = PL + 1 - ANGLE_BITS;    // last index of the bank delay line
   localparam int NV      = Q1 + PL + 3;            // stages before rsp register
   localparam int S2_POS  = Q1 + 2;                 // valid index of step stage

   localparam logic [Q1-1:0] HALF_Q = Q1'(1) << (ANGLE_BITS - 1);
   localparam logic signed [CORDIC_W-1:0] RND14 = CORDIC_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [ANGLE_BITS-1:0] cmd_h;
      logic [ANGLE_BITS-1:0] cur_h;
      logic [ANGLE_BITS-1:0] cmd_p;
      logic [ANGLE_BITS-1:0] cur_p;
   } ang_type;

   typedef struct packed {
      ang_type     ang;
      logic [16:0] ns;
      logic        big;
   } d1_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] nh;
      logic [ANGLE_BITS-1:0] np;
      logic [16:0]           ns;
   } pl_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } flag_type;

   function automatic logic signed [ANGLE_BITS:0] ang_move(
      input logic [ANGLE_BITS-1:0] cmd,
      input logic [ANGLE_BITS-1:0] cur,
      input logic [ANGLE_BITS-1:0] st
   );
      logic [ANGLE_BITS-1:0]        d;
      logic signed [ANGLE_BITS:0]   de, se, r;
      d  = cmd - cur;
      de = $signed({d[ANGLE_BITS-1], d});   // half circle reads negative
      se = $signed({1'b0, st});
      if (de > se)       r = se;
      else if (de < -se) r = -se;
      else               r = de;
      return r;
   endfunction

   function automatic logic signed [17:0] vel_out(
      input logic signed [CORDIC_W-1:0] v,
      input logic                       flip
   );
      logic signed [CORDIC_W-1:0] r;
      r = (v + RND14) >>> FRAC_BITS;
      if (flip) r = -r;
      if (r > CORDIC_W'(VEL_MAX)) return VEL_MAX;
      if (r < CORDIC_W'(VEL_MIN)) return VEL_MIN;
      return r[17:0];
   endfunction

   // ---------------------------------------------------------------- control
   logic            adv;
   logic [NV-1:0]   vld_ff, vld_in;
   logic            rsp_valid_ff;
   logic [9:0]      max_g_ff;
   logic [11:0]     max_accel_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NV-2:0], req_valid};
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_g_ff     <= MAX_G_RST;
         max_accel_ff <= MAX_ACCEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_G:     max_g_ff     <= csr_wdata[9:0];
            REG_MAX_ACCEL: max_accel_ff <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 0
   // capture, floor the speed, form max_g*dt and the speed limit
   ang_type     ang0_ff, ang0_in;
   logic [16:0] cmd_s0_ff, cur_s0_ff, sf0_ff, sf0_in;
   logic [25:0] prodg0_ff, prodg0_in;
   logic [27:0] acc_prod;
   logic [15:0] lim0_ff;

   assign ang0_in.cmd_h = ANGLE_BITS'(req_cmd_heading);
   assign ang0_in.cur_h = ANGLE_BITS'(req_cur_heading);
   assign ang0_in.cmd_p = ANGLE_BITS'($unsigned(req_cmd_pitch));
   assign ang0_in.cur_p = ANGLE_BITS'($unsigned(req_cur_pitch));
   assign sf0_in        = (req_cur_speed < 17'd256) ? 17'd256 : req_cur_speed;
   assign prodg0_in     = 26'(max_g_ff) * 26'(req_frame_time);
   assign acc_prod      = 28'(max_accel_ff) * 28'(req_frame_time);

   always_ff @(posedge clock) begin
      if (adv) begin
         ang0_ff   <= ang0_in;
         cmd_s0_ff <= req_cmd_speed;
         cur_s0_ff <= req_cur_speed;
         sf0_ff    <= sf0_in;
         prodg0_ff <= prodg0_in;
         lim0_ff   <= acc_prod[27:12];
      end
   end

   // ---------------------------------------------------------------- stage 1
   // turn numerator, clamped speed step
   ang_type            ang1_ff;
   logic [46:0]        num1_ff, num1_in;
   logic [16:0]        sf1_ff, ns1_ff, ns1_in;
   logic signed [17:0] ds_raw, lim_s, ds_cl, ns_sum;

   assign num1_in = 47'(prodg0_ff) * 47'(TURN_Q16);
   assign ds_raw  = $signed({1'b0, cmd_s0_ff}) - $signed({1'b0, cur_s0_ff});
   assign lim_s   = $signed({2'b00, lim0_ff});
   assign ds_cl   = (ds_raw > lim_s) ? lim_s : ((ds_raw < -lim_s) ? -lim_s : ds_raw);
   assign ns_sum  = $signed({1'b0, cur_s0_ff}) + ds_cl;
   assign ns1_in  = ns_sum[16:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff <= ang0_ff;
         num1_ff <= num1_in;
         sf1_ff  <= sf0_ff;
         ns1_ff  <= ns1_in;
      end
   end

   // ------------------------------------------------------- turn-step divider
   // quotient at or past half a circle is flagged up front; the cells only
   // need to be right below that
   logic [W1-1:0] div1_rem, div1_den;
   logic          big1;
   logic [Q1-1:0] q1;
   d1_type        d1_ff [0:Q1-1];

   assign div1_rem = W1'(num1_ff);
   assign div1_den = W1'(sf1_ff) << (32 - ANGLE_BITS);
   assign big1     = div1_rem >= (div1_den << (ANGLE_BITS - 1));

   rla_divider #(.W(W1), .QW(Q1)) u_step_div (
      .clock  (clock),
      .en     (adv),
      .rem_up (div1_rem),
      .den_up (div1_den),
      .quo_dn (q1)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff[0] <= '{ang: ang1_ff, ns: ns1_ff, big: big1};
         for (int i = 1; i < Q1; i++) d1_ff[i] <= d1_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- stage 2
   // cap the step at half a circle, move the angles
   logic [ANGLE_BITS-1:0]      step_w, mag_w;
   logic signed [ANGLE_BITS:0] dp_w, dh_w, dh_neg;
   pl_type                     pl2_ff, pl2_in;
   logic [ANGLE_BITS-1:0]      mag2_ff;
   logic [DW6-1:0]             den2_ff, den2_in;
   flag_type                   fl2_ff, fl2_in;
   d1_type                     d1_end;

   assign d1_end    = d1_ff[Q1-1];
   assign step_w    = (d1_end.big || (q1 >= HALF_Q)) ? HALF_Q[ANGLE_BITS-1:0] :
                      q1[ANGLE_BITS-1:0];
   assign dp_w      = ang_move(d1_end.ang.cmd_p, d1_end.ang.cur_p, step_w);
   assign dh_w      = ang_move(d1_end.ang.cmd_h, d1_end.ang.cur_h, step_w);
   assign dh_neg    = -dh_w;
   assign mag_w     = dh_w[ANGLE_BITS] ? dh_neg[ANGLE_BITS-1:0] : dh_w[ANGLE_BITS-1:0];
   assign pl2_in.np = d1_end.ang.cur_p + dp_w[ANGLE_BITS-1:0];
   assign pl2_in.nh = d1_end.ang.cur_h + dh_w[ANGLE_BITS-1:0];
   assign pl2_in.ns = d1_end.ns;
   assign den2_in   = DW6'(step_w) * DW6'(6);
   assign fl2_in    = '{neg: dh_w[ANGLE_BITS], zero: (step_w == '0)};

   always_ff @(posedge clock) begin
      if (adv) begin
         pl2_ff  <= pl2_in;
         mag2_ff <= mag_w;
         den2_ff <= den2_in;
         fl2_ff  <= fl2_in;
      end
   end

   // ---------------------------------------------------------- bank divider
   logic [W2-1:0]  div2_rem, div2_den;
   logic [Q2-1:0]  q2;
   flag_type       fl_ff [0:Q2-1];
   logic [31:0]    bq, bq_neg;
   logic [14:0]    bank_in;
   logic [14:0]    bk_ff [0:BL];

   assign div2_rem = W2'(mag2_ff) << ANGLE_BITS;
   assign div2_den = W2'(den2_ff);

   rla_divider #(.W(W2), .QW(Q2)) u_bank_div (
      .clock  (clock),
      .en     (adv),
      .rem_up (div2_rem),
      .den_up (div2_den),
      .quo_dn (q2)
   );

   assign bq      = 32'(q2);
   assign bq_neg  = -bq;
   assign bank_in = fl_ff[Q2-1].zero ? 15'd0 :
                    (fl_ff[Q2-1].neg ? bq_neg[14:0] : bq[14:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[0] <= fl2_ff;
         for (int i = 1; i < Q2; i++) fl_ff[i] <= fl_ff[i-1];
         bk_ff[0] <= bank_in;
         for (int i = 1; i <= BL; i++) bk_ff[i] <= bk_ff[i-1];
      end
   end

   // ------------------------------------------------------------- rotations
   // pitch rotation of the speed, then heading rotation of its horizontal part
   pl_type                     pl_ff [0:PL-1];
   logic signed [CORDIC_W-1:0] rot1_x, pc_w, ps_w, vn_w, ve_w;
   logic signed [CORDIC_W-1:0] ps_ff [0:ROT_LAT-1];

   assign rot1_x = $signed(CORDIC_W'(pl2_ff.ns) << FRAC_BITS);

   rla_rotator #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_rot_pitch (
      .clock  (clock),
      .en     (adv),
      .x_up   (rot1_x),
      .ang_up (pl2_ff.np),
      .x_dn   (pc_w),
      .y_dn   (ps_w)
   );

   rla_rotator #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_rot_head (
      .clock  (clock),
      .en     (adv),
      .x_up   (pc_w),
      .ang_up (pl_ff[ROT_LAT-1].nh),
      .x_dn   (vn_w),
      .y_dn   (ve_w)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff[0] <= pl2_ff;
         for (int i = 1; i < PL; i++) pl_ff[i] <= pl_ff[i-1];
         ps_ff[0] <= ps_w;
         for (int i = 1; i < ROT_LAT; i++) ps_ff[i] <= ps_ff[i-1];
      end
   end

   // ------------------------------------------------------ response register
   pl_type pl_end;

   assign pl_end = pl_ff[PL-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_new_heading <= 16'(pl_end.nh);
         rsp_new_pitch   <= $signed(16'(pl_end.np));
         rsp_bank_angle  <= $signed(bk_ff[BL]);
         rsp_new_speed   <= pl_end.ns;
         rsp_vel_north   <= vel_out(vn_w, 1'b0);
         rsp_vel_east    <= vel_out(ve_w, 1'b0);
         rsp_vel_down    <= vel_out(ps_ff[ROT_LAT-1], 1'b1);
      end
   end

`ifndef SYNTH
   // a response only appears when the last pipe stage held a word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[NV-1]))
      else $error("response valid without a word in the pipe");

   // a stalled response freezes the valid bits of every stage
   a_pipe_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(vld_ff))
      else $error("pipe moved while the response was stalled");

   // heading move never exceeds the turn step
   a_move_in_step: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[S2_POS] && !fl2_ff.zero) |-> ((DW6'(mag2_ff) * DW6'(6)) <= den2_ff))
      else $error("heading move beyond the turn step");
`endif

endmodule
